// ----- hw/rtl/itrd_pkg.sv -----
// itrd_pkg: widths, constants, control types and the digit-to-ASCII function
// for the integer to radix digits unit. No dependencies.
package itrd_pkg;

    localparam int VALUE_W      = 31;
    localparam int RADIX_W      = 6;
    localparam int DIGIT_W      = 6;
    localparam int CHAR_W       = 7;
    localparam int MAX_DIGITS_D = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO        = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_LETTER_BIAS = 7'd55;
    localparam logic [DIGIT_W-1:0] DECIMAL_TOP       = 6'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d > DECIMAL_TOP) begin
            res = {1'b0, d} + ASCII_LETTER_BIAS;
        end else begin
            res = {1'b0, d} + ASCII_ZERO;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/itrd_cell.sv -----
// itrd_cell: one digit cell of the systolic conversion row; doubles its digit
// and adds the incoming bit modulo the radix, passing the carry on. Uses itrd_pkg.
module itrd_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  itrd_pkg::cell_ctrl_t         ctrl,
    input  logic [itrd_pkg::RADIX_W-1:0] radix,
    input  logic                         bit_in,
    input  logic                         vld_in,
    input  logic [itrd_pkg::DIGIT_W-1:0] shift_digit,
    output logic [itrd_pkg::DIGIT_W-1:0] digit,
    output logic                         bit_out,
    output logic                         vld_out
);
    import itrd_pkg::*;

    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               bit_reg, bit_next;
    logic               vld_reg, vld_next;
    logic [DIGIT_W:0]   sum;
    logic [DIGIT_W:0]   diff;
    logic               ge;

    always_comb begin
        sum  = {digit_reg, bit_in};
        diff = sum - {1'b0, radix};
        ge   = (sum >= {1'b0, radix});

        digit_next = digit_reg;
        bit_next   = bit_reg;
        vld_next   = 1'b0;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.shift) begin
            digit_next = shift_digit;
        end else if (vld_in) begin
            digit_next = ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
            bit_next   = ge;
            vld_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
        bit_reg   <= bit_next;
    end

    assign digit   = digit_reg;
    assign bit_out = bit_reg;
    assign vld_out = vld_reg;

endmodule

// ----- hw/rtl/integer_to_radix_digits_unit.sv -----
// Integer to radix digits unit: converts a 31-bit unsigned value into upper-case
// ASCII digits of the configured radix (2 to 36, saturated), most significant
// first, the last character flagged. The value is shifted MSB first, one bit per
// cycle, into a row of MAX_DIGITS systolic digit cells. An item is accepted, fed
// through the cell row, its leading zero digits are shifted out, then its digits
// are delivered, held while the receiver stalls. A new value is accepted only
// once the last digit of the previous one is issued. Uses itrd_pkg and itrd_cell.
module integer_to_radix_digits_unit #(
    parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_D
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [itrd_pkg::RADIX_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [itrd_pkg::VALUE_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [itrd_pkg::CHAR_W-1:0]  m_digit_char,
    output logic                         m_last_digit
);
    import itrd_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W + MAX_DIGITS);
    localparam int REM_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] BITS_END  = CNT_W'(VALUE_W);
    localparam logic [CNT_W-1:0] FEED_LAST = CNT_W'(VALUE_W + MAX_DIGITS - 1);
    localparam logic [REM_W-1:0] REM_FULL  = REM_W'(MAX_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    cell_ctrl_t         ctrl;
    logic               feed_bit;
    logic               feed_vld;
    logic [DIGIT_W-1:0] digit_w [MAX_DIGITS];
    logic               bit_w   [MAX_DIGITS];
    logic               vld_w   [MAX_DIGITS];
    logic [DIGIT_W-1:0] top_digit;

    assign feed_bit  = value_reg[VALUE_W-1];
    assign top_digit = digit_w[MAX_DIGITS-1];

    // radix register, saturated at write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= sat_radix(cfg_wr_data);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
            logic               cell_bit;
            logic               cell_vld;
            logic [DIGIT_W-1:0] cell_shift;
            if (g == 0) begin : g_first
                assign cell_bit   = feed_bit;
                assign cell_vld   = feed_vld;
                assign cell_shift = '0;
            end else begin : g_rest
                assign cell_bit   = bit_w[g-1];
                assign cell_vld   = vld_w[g-1];
                assign cell_shift = digit_w[g-1];
            end
            itrd_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .radix       (radix_reg),
                .bit_in      (cell_bit),
                .vld_in      (cell_vld),
                .shift_digit (cell_shift),
                .digit       (digit_w[g]),
                .bit_out     (bit_w[g]),
                .vld_out     (vld_w[g])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        ctrl         = '0;
        feed_vld     = 1'b0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.clear = 1'b1;
                    value_next = s_value;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_FEED;
                end
            end
            ST_FEED: begin
                if (cnt_reg < BITS_END) begin
                    feed_vld   = 1'b1;
                    value_next = {value_reg[VALUE_W-2:0], 1'b0};
                end
                // carry dropped off the top cell means the digit row overflowed
                if (vld_w[MAX_DIGITS-1] && bit_w[MAX_DIGITS-1]) begin
                    ovf_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == FEED_LAST) begin
                    rem_next   = REM_FULL;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!ovf_reg && rem_reg > REM_ONE && top_digit == '0) begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    ctrl.shift   = 1'b1;
                    m_valid_next = 1'b1;
                    char_next    = digit_to_ascii(top_digit);
                    last_next    = (rem_reg == REM_ONE);
                    rem_next     = rem_reg - 1'b1;
                    if (rem_reg == REM_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_digit_char = char_reg;
    assign m_last_digit = last_reg;

endmodule

// ----- dv/integer_to_radix_digits_unit_tb.sv -----
// Self-checking testbench for integer_to_radix_digits_unit: drives values, writes the radix
// between phases and checks every digit against known text or a predictor. Uses itrd_pkg.
// Runs directed cases first, then random values under several idle and stall patterns.
module integer_to_radix_digits_unit_tb;
    import itrd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 200;
    localparam int NUM_PHASES     = 13;
    localparam int PHASE_ITEMS    = 27;
    localparam int NUM_CASES      = 23;

    localparam logic [VALUE_W-1:0] VALUE_TOP = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } digit_xfer_t;

    typedef struct {
        logic [RADIX_W-1:0] radix;
        logic [VALUE_W-1:0] value;
        string              known;
    } conv_case_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [RADIX_W-1:0]  cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CHAR_W-1:0]   m_digit_char;
    logic                m_last_digit;

    digit_xfer_t         pending_digits[$];
    digit_xfer_t         want;
    logic [RADIX_W-1:0]  radix_shadow = RADIX_RESET;
    int                  mismatch_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_requests = 0;
    int                  holds_served = 0;
    int                  hold_left = 0;
    int                  quiet_cycles = 0;

    conv_case_t directed_cases [NUM_CASES] = '{
        '{6'd10, 31'd0,          "0"},
        '{6'd10, 31'd1,          "1"},
        '{6'd10, 31'd9,          "9"},
        '{6'd10, 31'd10,         "10"},
        '{6'd10, VALUE_TOP,      "2147483647"},
        '{6'd10, 31'd1000000000, "1000000000"},
        '{6'd2,  31'd0,          "0"},
        '{6'd2,  31'd1,          "1"},
        '{6'd2,  31'd6,          "110"},
        '{6'd2,  VALUE_TOP,      ""},
        '{6'd2,  31'h4000_0000,  ""},
        '{6'd2,  31'h5555_5555,  ""},
        '{6'd36, 31'd35,         "Z"},
        '{6'd36, 31'd36,         "10"},
        '{6'd36, VALUE_TOP,      ""},
        '{6'd16, 31'd255,        "FF"},
        '{6'd16, VALUE_TOP,      "7FFFFFFF"},
        '{6'd16, 31'h0ABC_DEF9,  "ABCDEF9"},
        '{6'd0,  31'd5,          "101"},
        '{6'd1,  31'd6,          "110"},
        '{6'd37, 31'd35,         "Z"},
        '{6'd63, 31'd71,         "1Z"},
        '{6'd3,  VALUE_TOP,      ""}
    };

    integer_to_radix_digits_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic int effective_base(input logic [RADIX_W-1:0] r);
        int base;
        base = r;
        if (r < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        return base;
    endfunction

    // remainders come out least significant first, so push them in reverse
    function automatic void predict_digits(input logic [VALUE_W-1:0] v,
                                           input logic [RADIX_W-1:0] r);
        logic [DIGIT_W-1:0] rems [MAX_DIGITS_D];
        logic [VALUE_W-1:0] rest;
        logic [CHAR_W-1:0]  ch;
        int                 base;
        int                 n;
        int                 k;
        base = effective_base(r);
        rest = v;
        n = 0;
        if (rest == '0) begin
            rems[0] = '0;
            n = 1;
        end else begin
            while (rest != '0 && n < MAX_DIGITS_D) begin
                rems[n] = DIGIT_W'(rest % base);
                rest = VALUE_W'(rest / base);
                n++;
            end
        end
        if (n > VALUE_W) begin
            n = VALUE_W;
        end
        for (k = n - 1; k >= 0; k--) begin
            if (rems[k] > DECIMAL_TOP) begin
                ch = {1'b0, rems[k]} + ASCII_LETTER_BIAS;
            end else begin
                ch = {1'b0, rems[k]} + ASCII_ZERO;
            end
            pending_digits.push_back('{ch, k == 0});
        end
    endfunction

    function automatic void expect_text(input string text);
        byte c;
        int  i;
        for (i = 0; i < text.len(); i++) begin
            c = text[i];
            pending_digits.push_back('{c[CHAR_W-1:0], i == text.len() - 1});
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
        logic [VALUE_W-1:0] v;
        longint             p;
        int                 base;
        int                 k;
        base = effective_base(r);
        case ($urandom_range(9))
            0: v = '0;
            1: v = VALUE_TOP;
            2: v = VALUE_W'($urandom_range(base * base));
            3, 4: begin
                // powers of the radix and one below
                p = 1;
                k = $urandom_range(1, VALUE_W);
                while (k > 0 && p * base <= VALUE_TOP) begin
                    p = p * base;
                    k--;
                end
                v = VALUE_W'(p - $urandom_range(1));
            end
            5: v = VALUE_W'($urandom);
            default: v = VALUE_W'($urandom) & (VALUE_TOP >> $urandom_range(VALUE_W - 1));
        endcase
        return v;
    endfunction

    function automatic void set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 76;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = 76;
            end
            default: begin
                send_idle_pct = 20;
                recv_stall_pct = 20;
            end
        endcase
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v, input string known);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (known.len() != 0) begin
            expect_text(known);
        end else begin
            predict_digits(v, radix_shadow);
        end
    endtask

    task automatic wait_for_digits();
        s_valid <= 1'b0;
        while (pending_digits.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_for_digits();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        radix_shadow = r;
    endtask

    // result side: check the transfer, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_digits.size() == 0) begin
                $error("unexpected digit transfer: digit_char %0d last_digit %0d",
                       m_digit_char, m_last_digit);
                mismatch_count++;
            end else begin
                want = pending_digits.pop_front();
                if (m_digit_char !== want.digit_char) begin
                    $error("digit_char mismatch: expected %0d, actual %0d",
                           want.digit_char, m_digit_char);
                    mismatch_count++;
                end
                if (m_last_digit !== want.last_digit) begin
                    $error("last_digit mismatch: expected %0d, actual %0d",
                           want.last_digit, m_last_digit);
                    mismatch_count++;
                end
            end
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("integer_to_radix_digits_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [RADIX_W-1:0] phase_radix;
        int                 ph;
        int                 i;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle(IDLE_NONE);
        for (i = 0; i < NUM_CASES; i++) begin
            if (directed_cases[i].radix != radix_shadow) begin
                write_radix(directed_cases[i].radix);
            end
            send_value(directed_cases[i].value, directed_cases[i].known);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: phase_radix = RADIX_MIN;
                1: phase_radix = RADIX_MAX;
                2: phase_radix = 6'd16;
                3: phase_radix = 6'd0;
                4: phase_radix = RADIX_RESET;
                5: phase_radix = 6'd63;
                6: phase_radix = 6'd1;
                7: phase_radix = 6'd37;
                default: phase_radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            endcase
            write_radix(phase_radix);
            set_idle(idle_mode_t'(ph % 4));
            // receiver holds off while values keep coming, so the input backs up
            if (ph == 4) begin
                hold_requests <= hold_requests + 1;
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_value(pick_value(phase_radix), "");
            end
        end

        wait_for_digits();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("integer_to_radix_digits_unit regression: pass");
        end else begin
            $display("integer_to_radix_digits_unit regression: fail");
        end
        $finish;
    end

endmodule
